// ===== sv/gastar_pkg.sv =====
package gastar_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int FRAC_BITS  = 4;

  localparam int NCELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_W  = $clog2(NCELLS);
  localparam int CNT_W   = CELL_W + 1;
  localparam int COORD_W = 5;
  localparam int DIM_W   = 6;
  localparam int COST_W  = 20;
  localparam int SCORE_W = 21;

  // integer root: operand holds (dx^2 + dy^2) << 2F, rounded up to an even width
  localparam int SQ_W = 12 + 2 * FRAC_BITS;
  localparam int HW   = SQ_W / 2;

  localparam logic [COST_W-1:0] COST_INF      = '1;
  localparam logic [COST_W-1:0] STEP_STRAIGHT = COST_W'(10 << FRAC_BITS);
  localparam logic [COST_W-1:0] STEP_DIAG     = COST_W'(14 << FRAC_BITS);

  // cost store word: {valid, came_from, cost}
  localparam int CM_W = 1 + CELL_W + COST_W;
  // open list word: {cell, score}
  localparam int OM_W = CELL_W + SCORE_W;

  localparam logic [1:0] KIND_OBST   = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HEUR   = 2'd2;

  localparam logic [1:0] HEUR_EUCLID = 2'd0;
  localparam logic [1:0] HEUR_MANH   = 2'd1;
  localparam logic [1:0] HEUR_CHEB   = 2'd2;
  localparam logic [1:0] HEUR_ZERO   = 2'd3;

  function automatic logic [CELL_W-1:0] cell_idx(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    cell_idx = CELL_W'(int'(y) * MAX_WIDTH + int'(x));
  endfunction

  function automatic logic [COORD_W-1:0] cell_col(input logic [CELL_W-1:0] c);
    cell_col = COORD_W'(c % MAX_WIDTH);
  endfunction

  function automatic logic [COORD_W-1:0] cell_row(input logic [CELL_W-1:0] c);
    cell_row = COORD_W'(c / MAX_WIDTH);
  endfunction

endpackage

// ===== sv/gastar_ram.sv =====
module gastar_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== sv/gastar_heur.sv =====
module gastar_heur
  import gastar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  logic [COORD_W-1:0] x_i,
  input  logic [COORD_W-1:0] y_i,
  input  logic [COORD_W-1:0] gx_i,
  input  logic [COORD_W-1:0] gy_i,
  output logic               done_o,
  output logic [HW-1:0]      h_o
);

  logic [COORD_W-1:0] dx, dy, dmax;
  logic [SQ_W-1:0]    d2;
  logic [SQ_W-1:0]    v_q, v_d, r_q, r_d, bit_q, bit_d, rb;
  logic               run_q, run_d, done_q, done_d;
  logic [HW-1:0]      h_q, h_d;

  always_comb begin
    dx   = (x_i > gx_i) ? x_i - gx_i : gx_i - x_i;
    dy   = (y_i > gy_i) ? y_i - gy_i : gy_i - y_i;
    dmax = (dx > dy) ? dx : dy;
    d2   = (SQ_W'(dx) * SQ_W'(dx) + SQ_W'(dy) * SQ_W'(dy)) << (2 * FRAC_BITS);
    rb   = r_q + bit_q;
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    run_d  = run_q;
    done_d = 1'b0;
    h_d    = h_q;
    if (start_i) begin
      unique case (mode_i)
        HEUR_EUCLID: begin
          v_d   = d2;
          r_d   = '0;
          bit_d = SQ_W'(1) << (SQ_W - 2);
          run_d = 1'b1;
        end
        HEUR_MANH: begin
          h_d    = HW'((HW'(dx) + HW'(dy)) << FRAC_BITS);
          done_d = 1'b1;
        end
        HEUR_CHEB: begin
          h_d    = HW'(HW'(dmax) << FRAC_BITS);
          done_d = 1'b1;
        end
        default: begin
          h_d    = '0;
          done_d = 1'b1;
        end
      endcase
    end else if (run_q) begin
      if (v_q >= rb) begin
        v_d = v_q - rb;
        r_d = (r_q >> 1) + bit_q;
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == SQ_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
        h_d    = r_d[HW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      h_q    <= '0;
    end else begin
      v_q    <= v_d;
      r_q    <= r_d;
      bit_q  <= bit_d;
      run_q  <= run_d;
      done_q <= done_d;
      h_q    <= h_d;
    end
  end

  assign done_o = done_q;
  assign h_o    = h_q;

endmodule

// ===== sv/grid_astar_path_search_top.sv =====
// A* search on an 8-connected grid of up to 32x32 cells. A command is taken when start_i
// is high and busy_o is low; each command gives one result, shown for exactly one cycle
// with done_o high, and the receiver cannot stall it. After reset the obstacle map is
// cleared with busy_o high. A search first clears the cost store, then for each expanded
// cell scans the open list, closes the gap left by the taken entry and tries 8 neighbors;
// an improved neighbor gets a heuristic and a search of the open list. The path is then
// rebuilt from the came-from links. The open list memory port bounds the run time.
module grid_astar_path_search_top
  import gastar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         kind_i,
  input  logic [COORD_W-1:0] cell_x_i,
  input  logic [COORD_W-1:0] cell_y_i,
  input  logic               blocked_i,
  input  logic [COORD_W-1:0] goal_x_i,
  input  logic [COORD_W-1:0] goal_y_i,
  input  logic [9:0]         step_index_i,
  output logic               done_o,
  output logic               found_o,
  output logic [10:0]        path_length_o,
  output logic [COORD_W-1:0] step_x_o,
  output logic [COORD_W-1:0] step_y_o,
  output logic               step_valid_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_data_i
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RDW   = 5'd2;
  localparam logic [4:0] S_SCLR  = 5'd3;
  localparam logic [4:0] S_SINIT = 5'd4;
  localparam logic [4:0] S_SHEUR = 5'd5;
  localparam logic [4:0] S_SCAN0 = 5'd6;
  localparam logic [4:0] S_SCAN  = 5'd7;
  localparam logic [4:0] S_PICK  = 5'd8;
  localparam logic [4:0] S_SH    = 5'd9;
  localparam logic [4:0] S_SHW   = 5'd10;
  localparam logic [4:0] S_GCUR  = 5'd11;
  localparam logic [4:0] S_NB    = 5'd12;
  localparam logic [4:0] S_NBCHK = 5'd13;
  localparam logic [4:0] S_NBH   = 5'd14;
  localparam logic [4:0] S_FIND  = 5'd15;
  localparam logic [4:0] S_FINDC = 5'd16;
  localparam logic [4:0] S_PB1   = 5'd17;
  localparam logic [4:0] S_PB2   = 5'd18;

  logic [4:0]         state_q, state_d;
  logic [DIM_W-1:0]   wid_q, hei_q, w_eff, h_eff;
  logic [1:0]         mode_q;
  logic [CNT_W-1:0]   idx_q, idx_d, cnt_q, cnt_d, pcnt_q, pcnt_d;
  logic [COORD_W-1:0] sx_q, sx_d, sy_q, sy_d, gx_q, gx_d, gy_q, gy_d;
  logic [COORD_W-1:0] nbx_q, nbx_d, nby_q, nby_d;
  logic [CELL_W-1:0]  goal_q, goal_d, cur_q, cur_d, li_q, li_d, nb_q, nb_d;
  logic [COST_W-1:0]  gcur_q, gcur_d, tg_q, tg_d;
  logic [SCORE_W-1:0] min_q, min_d, f_q, f_d;
  logic [2:0]         nbi_q, nbi_d;
  logic               diag_q, diag_d, found_q, found_d;
  logic               done_q, done_d, sv_q, sv_d;
  logic [COORD_W-1:0] stx_q, stx_d, sty_q, sty_d;

  logic               obs_we, obs_wd, obs_rd;
  logic [CELL_W-1:0]  obs_wa, obs_ra;
  logic               cm_we;
  logic [CELL_W-1:0]  cm_wa, cm_ra;
  logic [CM_W-1:0]    cm_wd, cm_rd;
  logic               om_we;
  logic [CELL_W-1:0]  om_wa, om_ra;
  logic [OM_W-1:0]    om_wd, om_rd;
  logic               pm_we;
  logic [CELL_W-1:0]  pm_wa, pm_ra, pm_wd, pm_rd;

  logic               h_start, h_done;
  logic [COORD_W-1:0] h_x, h_y;
  logic [HW-1:0]      h_val;

  logic               accept;
  logic [1:0]         ox, oy;
  logic [COORD_W-1:0] cx, cy;
  logic [DIM_W-1:0]   nx, ny;
  logic               nb_ok;
  logic [COST_W:0]    tg_sum;
  logic [SCORE_W-1:0] o_score;
  logic [CELL_W-1:0]  o_cell, cm_from;
  logic               cm_valid;
  logic [CELL_W-1:0]  start_idx;

  gastar_ram #(.W(1), .D(NCELLS)) u_obs (
    .clk_i, .we_i(obs_we), .waddr_i(obs_wa), .wdata_i(obs_wd),
    .raddr_i(obs_ra), .rdata_o(obs_rd)
  );
  gastar_ram #(.W(CM_W), .D(NCELLS)) u_cost (
    .clk_i, .we_i(cm_we), .waddr_i(cm_wa), .wdata_i(cm_wd),
    .raddr_i(cm_ra), .rdata_o(cm_rd)
  );
  gastar_ram #(.W(OM_W), .D(NCELLS)) u_open (
    .clk_i, .we_i(om_we), .waddr_i(om_wa), .wdata_i(om_wd),
    .raddr_i(om_ra), .rdata_o(om_rd)
  );
  gastar_ram #(.W(CELL_W), .D(NCELLS)) u_path (
    .clk_i, .we_i(pm_we), .waddr_i(pm_wa), .wdata_i(pm_wd),
    .raddr_i(pm_ra), .rdata_o(pm_rd)
  );

  gastar_heur u_heur (
    .clk_i, .rst_ni, .start_i(h_start), .mode_i(mode_q),
    .x_i(h_x), .y_i(h_y), .gx_i(gx_q), .gy_i(gy_q),
    .done_o(h_done), .h_o(h_val)
  );

  assign busy_o      = state_q != S_IDLE;
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  assign w_eff = (wid_q == '0) ? DIM_W'(1) :
                 (wid_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : wid_q;
  assign h_eff = (hei_q == '0) ? DIM_W'(1) :
                 (hei_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : hei_q;

  assign o_score   = om_rd[SCORE_W-1:0];
  assign o_cell    = om_rd[OM_W-1:SCORE_W];
  assign cm_valid  = cm_rd[CM_W-1];
  assign cm_from   = cm_rd[COST_W +: CELL_W];
  assign start_idx = cell_idx(sx_q, sy_q);

  // neighbor offsets: 0 is -1, 1 is 0, 2 is +1
  always_comb begin
    unique case (nbi_q)
      3'd0: begin ox = 2'd0; oy = 2'd0; end
      3'd1: begin ox = 2'd0; oy = 2'd1; end
      3'd2: begin ox = 2'd0; oy = 2'd2; end
      3'd3: begin ox = 2'd1; oy = 2'd0; end
      3'd4: begin ox = 2'd1; oy = 2'd2; end
      3'd5: begin ox = 2'd2; oy = 2'd0; end
      3'd6: begin ox = 2'd2; oy = 2'd1; end
      default: begin ox = 2'd2; oy = 2'd2; end
    endcase
    cx    = cell_col(cur_q);
    cy    = cell_row(cur_q);
    nx    = DIM_W'(cx) + DIM_W'(ox) - DIM_W'(1);
    ny    = DIM_W'(cy) + DIM_W'(oy) - DIM_W'(1);
    nb_ok = !(ox == 2'd0 && cx == '0) && !(oy == 2'd0 && cy == '0) &&
            (nx < w_eff) && (ny < h_eff);
    tg_sum = {1'b0, gcur_q} + {1'b0, (diag_q ? STEP_DIAG : STEP_STRAIGHT)};
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    pcnt_d  = pcnt_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    gx_d    = gx_q;
    gy_d    = gy_q;
    nbx_d   = nbx_q;
    nby_d   = nby_q;
    goal_d  = goal_q;
    cur_d   = cur_q;
    li_d    = li_q;
    nb_d    = nb_q;
    gcur_d  = gcur_q;
    tg_d    = tg_q;
    min_d   = min_q;
    f_d     = f_q;
    nbi_d   = nbi_q;
    diag_d  = diag_q;
    found_d = found_q;
    done_d  = 1'b0;
    sv_d    = sv_q;
    stx_d   = stx_q;
    sty_d   = sty_q;

    obs_we = 1'b0;
    obs_wa = idx_q[CELL_W-1:0];
    obs_wd = 1'b0;
    obs_ra = nb_q;
    cm_we  = 1'b0;
    cm_wa  = idx_q[CELL_W-1:0];
    cm_wd  = {1'b0, {CELL_W{1'b0}}, COST_INF};
    cm_ra  = cur_q;
    om_we  = 1'b0;
    om_wa  = idx_q[CELL_W-1:0];
    om_wd  = {nb_q, f_q};
    om_ra  = idx_q[CELL_W-1:0];
    pm_we  = 1'b0;
    pm_wa  = CELL_W'(idx_q - CNT_W'(1));
    pm_wd  = cm_from;
    pm_ra  = step_index_i;
    h_start = 1'b0;
    h_x     = nbx_q;
    h_y     = nby_q;

    unique case (state_q)
      S_CLR: begin
        obs_we = 1'b1;
        if (idx_q == CNT_W'(NCELLS - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          sv_d  = 1'b0;
          stx_d = '0;
          sty_d = '0;
          unique case (kind_i)
            KIND_OBST: begin
              obs_we  = 1'b1;
              obs_wa  = cell_idx(cell_x_i, cell_y_i);
              obs_wd  = blocked_i;
              done_d  = 1'b1;
            end
            KIND_SEARCH: begin
              found_d = 1'b0;
              pcnt_d  = '0;
              cnt_d   = '0;
              sx_d    = cell_x_i;
              sy_d    = cell_y_i;
              gx_d    = goal_x_i;
              gy_d    = goal_y_i;
              goal_d  = cell_idx(goal_x_i, goal_y_i);
              idx_d   = '0;
              if (DIM_W'(cell_x_i) >= w_eff || DIM_W'(cell_y_i) >= h_eff ||
                  DIM_W'(goal_x_i) >= w_eff || DIM_W'(goal_y_i) >= h_eff) begin
                done_d = 1'b1;
              end else begin
                state_d = S_SCLR;
              end
            end
            KIND_READ: begin
              if (CNT_W'(step_index_i) < pcnt_q) begin
                state_d = S_RDW;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RDW: begin
        sv_d    = 1'b1;
        stx_d   = cell_col(pm_rd);
        sty_d   = cell_row(pm_rd);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCLR: begin
        cm_we = 1'b1;
        if (idx_q == CNT_W'(NCELLS - 1)) begin
          state_d = S_SINIT;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      S_SINIT: begin
        cm_we   = 1'b1;
        cm_wa   = start_idx;
        cm_wd   = '0;
        h_start = 1'b1;
        h_x     = sx_q;
        h_y     = sy_q;
        state_d = S_SHEUR;
      end
      S_SHEUR: begin
        if (h_done) begin
          om_we   = 1'b1;
          om_wa   = '0;
          om_wd   = {start_idx, SCORE_W'(h_val)};
          cnt_d   = CNT_W'(1);
          state_d = S_SCAN0;
        end
      end
      S_SCAN0: begin
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          om_ra   = '0;
          idx_d   = CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_q == CNT_W'(1) || o_score < min_q) begin
          min_d = o_score;
          li_d  = CELL_W'(idx_q - CNT_W'(1));
          cur_d = o_cell;
        end
        if (idx_q < cnt_q) begin
          om_ra = idx_q[CELL_W-1:0];
          idx_d = idx_q + CNT_W'(1);
        end else begin
          state_d = S_PICK;
        end
      end
      S_PICK: begin
        if (cur_q == goal_q) begin
          found_d = 1'b1;
          idx_d   = '0;
          cm_ra   = goal_q;
          state_d = S_PB1;
        end else begin
          idx_d   = CNT_W'(li_q) + CNT_W'(1);
          state_d = S_SH;
        end
      end
      S_SH: begin
        if (idx_q < cnt_q) begin
          om_ra   = idx_q[CELL_W-1:0];
          state_d = S_SHW;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          cm_ra   = cur_q;
          state_d = S_GCUR;
        end
      end
      S_SHW: begin
        om_we   = 1'b1;
        om_wa   = CELL_W'(idx_q - CNT_W'(1));
        om_wd   = om_rd;
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_SH;
      end
      S_GCUR: begin
        gcur_d  = cm_rd[COST_W-1:0];
        nbi_d   = '0;
        state_d = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          nbx_d   = nx[COORD_W-1:0];
          nby_d   = ny[COORD_W-1:0];
          nb_d    = cell_idx(nx[COORD_W-1:0], ny[COORD_W-1:0]);
          diag_d  = (ox != 2'd1) && (oy != 2'd1);
          obs_ra  = cell_idx(nx[COORD_W-1:0], ny[COORD_W-1:0]);
          cm_ra   = cell_idx(nx[COORD_W-1:0], ny[COORD_W-1:0]);
          state_d = S_NBCHK;
        end else if (nbi_q == 3'd7) begin
          state_d = S_SCAN0;
        end else begin
          nbi_d = nbi_q + 3'd1;
        end
      end
      S_NBCHK: begin
        if (!obs_rd && tg_sum < {1'b0, cm_rd[COST_W-1:0]}) begin
          tg_d    = tg_sum[COST_W-1:0];
          h_start = 1'b1;
          state_d = S_NBH;
        end else if (nbi_q == 3'd7) begin
          state_d = S_SCAN0;
        end else begin
          nbi_d   = nbi_q + 3'd1;
          state_d = S_NB;
        end
      end
      S_NBH: begin
        if (h_done) begin
          f_d     = SCORE_W'(tg_q) + SCORE_W'(h_val);
          cm_we   = 1'b1;
          cm_wa   = nb_q;
          cm_wd   = {1'b1, cur_q, tg_q};
          idx_d   = '0;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (idx_q < cnt_q) begin
          om_ra   = idx_q[CELL_W-1:0];
          state_d = S_FINDC;
        end else begin
          if (cnt_q < CNT_W'(NCELLS)) begin
            om_we = 1'b1;
            om_wa = cnt_q[CELL_W-1:0];
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (nbi_q == 3'd7) begin
            state_d = S_SCAN0;
          end else begin
            nbi_d   = nbi_q + 3'd1;
            state_d = S_NB;
          end
        end
      end
      S_FINDC: begin
        if (o_cell == nb_q) begin
          om_we = 1'b1;
          om_wa = idx_q[CELL_W-1:0];
          if (nbi_q == 3'd7) begin
            state_d = S_SCAN0;
          end else begin
            nbi_d   = nbi_q + 3'd1;
            state_d = S_NB;
          end
        end else begin
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_FIND;
        end
      end
      S_PB1: begin
        if (cm_valid && idx_q < CNT_W'(NCELLS)) begin
          idx_d = idx_q + CNT_W'(1);
          cm_ra = cm_from;
        end else begin
          pcnt_d = idx_q;
          if (idx_q == '0) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            cm_ra   = goal_q;
            state_d = S_PB2;
          end
        end
      end
      S_PB2: begin
        pm_we = 1'b1;
        if (idx_q == CNT_W'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q - CNT_W'(1);
          cm_ra = cm_from;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      wid_q   <= DIM_W'(32);
      hei_q   <= DIM_W'(32);
      mode_q  <= HEUR_EUCLID;
      idx_q   <= '0;
      cnt_q   <= '0;
      pcnt_q  <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
      sv_q    <= 1'b0;
      stx_q   <= '0;
      sty_q   <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      gx_q    <= '0;
      gy_q    <= '0;
      nbx_q   <= '0;
      nby_q   <= '0;
      goal_q  <= '0;
      cur_q   <= '0;
      li_q    <= '0;
      nb_q    <= '0;
      gcur_q  <= '0;
      tg_q    <= '0;
      min_q   <= '0;
      f_q     <= '0;
      nbi_q   <= '0;
      diag_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_WIDTH:  wid_q  <= cfg_data_i;
          REG_HEIGHT: hei_q  <= cfg_data_i;
          REG_HEUR:   mode_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      pcnt_q  <= pcnt_d;
      found_q <= found_d;
      done_q  <= done_d;
      sv_q    <= sv_d;
      stx_q   <= stx_d;
      sty_q   <= sty_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      gx_q    <= gx_d;
      gy_q    <= gy_d;
      nbx_q   <= nbx_d;
      nby_q   <= nby_d;
      goal_q  <= goal_d;
      cur_q   <= cur_d;
      li_q    <= li_d;
      nb_q    <= nb_d;
      gcur_q  <= gcur_d;
      tg_q    <= tg_d;
      min_q   <= min_d;
      f_q     <= f_d;
      nbi_q   <= nbi_d;
      diag_q  <= diag_d;
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign path_length_o = pcnt_q;
  assign step_x_o      = stx_q;
  assign step_y_o      = sty_q;
  assign step_valid_o  = sv_q;

endmodule
